### hdl/sha256_pkg.sv
package sha256_pkg;

	typedef logic [31:0] word_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd7;

	localparam word_t K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// byte write into the schedule window
	typedef struct packed {
		logic       en;
		logic [5:0] idx;
		logic [7:0] data;
	} wr_t;

	typedef struct packed {
		logic start;
		logic init;
	} cmp_ctl_t;

	typedef struct packed {
		logic round_en;
		logic done;
	} cmp_sts_t;

endpackage

### hdl/sha256_if.sv
interface sha256_in_if;
	import sha256_pkg::*;

	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface sha256_out_if;
	import sha256_pkg::*;

	logic       valid;
	logic       ready;
	word_t      digest_word;
	logic [2:0] word_index;
	logic       last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

### hdl/sha256_sched.sv
module sha256_sched (
	input  logic               clk,
	input  sha256_pkg::wr_t    wr,
	input  logic               shift,
	output sha256_pkg::word_t  w_t
);
	import sha256_pkg::*;

	word_t win_q [16];
	word_t w_new;

	function automatic word_t sig0(input word_t x);
		sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
	endfunction

	assign w_new = win_q[0] + sig0(win_q[1]) + win_q[9] + sig1(win_q[14]);
	assign w_t   = win_q[0];

	// bytes land most significant first; advance the window once per round
	always_ff @(posedge clk) begin
		if (wr.en) begin
			win_q[wr.idx[5:2]][{~wr.idx[1:0], 3'b000} +: 8] <= wr.data;
		end else if (shift) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
		end
	end

endmodule

### hdl/sha256_compress.sv
module sha256_compress (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha256_pkg::cmp_ctl_t ctl,
	input  sha256_pkg::word_t    w_t,
	output sha256_pkg::cmp_sts_t sts,
	output sha256_pkg::word_t    hash [8]
);
	import sha256_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} cstate_t;

	cstate_t    state_q;
	logic [5:0] cnt_q;
	word_t      hash_q [8];
	word_t      a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	word_t      s0, s1, ch, mj, t1;

	assign s1 = {e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]};
	assign ch = (e_q & f_q) ^ (~e_q & g_q);
	assign t1 = h_q + s1 + ch + K_TABLE[cnt_q] + w_t;
	assign s0 = {a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]};
	assign mj = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);

	assign sts.round_en = (state_q == C_ROUND);
	assign sts.done     = (state_q == C_FINAL);
	assign hash         = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			hash_q  <= H_INIT;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					cnt_q <= '0;
					if (ctl.start) begin
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == FILL_LAST) begin
						state_q <= C_FINAL;
					end
				end
				C_FINAL: begin
					hash_q[0] <= hash_q[0] + a_q;
					hash_q[1] <= hash_q[1] + b_q;
					hash_q[2] <= hash_q[2] + c_q;
					hash_q[3] <= hash_q[3] + d_q;
					hash_q[4] <= hash_q[4] + e_q;
					hash_q[5] <= hash_q[5] + f_q;
					hash_q[6] <= hash_q[6] + g_q;
					hash_q[7] <= hash_q[7] + h_q;
					state_q   <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
			if (ctl.init) begin
				hash_q <= H_INIT;
			end
		end
	end

	// working variables
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctl.start) begin
			a_q <= hash_q[0]; b_q <= hash_q[1]; c_q <= hash_q[2]; d_q <= hash_q[3];
			e_q <= hash_q[4]; f_q <= hash_q[5]; g_q <= hash_q[6]; h_q <= hash_q[7];
		end else if (state_q == C_ROUND) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + s0 + mj;
		end
	end

endmodule

### hdl/sha256_stream_hasher_unit.sv
// SHA-256 hasher over a byte stream.
// Input channel msg: each transfer carries operation and data_byte. Operation
// absorb appends data_byte to the current message; operation finish pads the
// message, hashes the tail and produces the digest.
// Output channel digest: eight transfers per finished message, digest_word is
// one hash word (most significant byte first), word_index counts 0..7, and
// last_word marks the eighth.
// Flow: absorbs are taken back to back while the block is idle; the byte that
// fills a 64-byte block stops input while it is compressed (a load step, 64
// rounds through the single round unit, a fold into the hash words). A finish
// pads from the fill position to the end of the block and compresses it,
// adding a second padded block for the length when more than 55 bytes are
// held, all before the first digest word; one word follows per cycle when
// the receiver takes them. The block does not take input from a finish until
// the eighth word has entered the output register.
// Reset clears the hash words to their initial values, the fill count and the
// byte count. A stall on digest holds the current word in the output register
// and pauses the word sequence; absorb transfers resume once the eighth word
// is loaded, even while it still waits to be taken.
module sha256_stream_hasher_unit (
	input  logic         clk,
	input  logic         arst_n,
	sha256_in_if.sink    msg,
	sha256_out_if.source digest
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_PAD, S_CMP_GO, S_CMP_WAIT, S_OUT} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] octets_q;
	logic [5:0]  pad_idx_q;
	logic        first_q;
	logic        len_here_q;
	logic        finishing_q;
	logic [2:0]  word_q;
	logic        out_valid_q;
	word_t       out_word_q;
	logic [2:0]  out_index_q;
	logic        out_last_q;

	logic [63:0] bit_len;
	logic [7:0]  pad_byte;
	logic        out_load;
	wr_t         wr;
	cmp_ctl_t    ctl;
	cmp_sts_t    sts;
	word_t       w_t;
	word_t       hash [8];

	assign msg.ready          = (state_q == S_IDLE);
	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_index_q;
	assign digest.last_word   = out_last_q;

	assign bit_len  = {octets_q[60:0], 3'b000};
	assign out_load = (state_q == S_OUT) && (!out_valid_q || digest.ready);

	// padding: marker first, zeros, then the big-endian bit length in the
	// last eight bytes of the final block
	always_comb begin
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (len_here_q && pad_idx_q >= LEN_POS) begin
			pad_byte = bit_len[{~pad_idx_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = '0;
		end
	end

	always_comb begin
		wr = '0;
		if (state_q == S_IDLE && msg.valid && msg.operation == OP_ABSORB) begin
			wr.en   = 1'b1;
			wr.idx  = fill_q;
			wr.data = msg.data_byte;
		end else if (state_q == S_PAD) begin
			wr.en   = 1'b1;
			wr.idx  = pad_idx_q;
			wr.data = pad_byte;
		end
	end

	// restart the chaining value as the eighth word is loaded into the output register
	assign ctl.start = (state_q == S_CMP_GO);
	assign ctl.init  = out_load && (word_q == WORD_LAST);

	sha256_sched u_sched (
		.clk   (clk),
		.wr    (wr),
		.shift (sts.round_en),
		.w_t   (w_t)
	);

	sha256_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w_t    (w_t),
		.sts    (sts),
		.hash   (hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			octets_q    <= '0;
			pad_idx_q   <= '0;
			first_q     <= 1'b0;
			len_here_q  <= 1'b0;
			finishing_q <= 1'b0;
			word_q      <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_index_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// load the next word, or drop the current one once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_word_q  <= hash[word_q];
				out_index_q <= word_q;
				out_last_q  <= (word_q == WORD_LAST);
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (msg.valid) begin
						if (msg.operation == OP_ABSORB) begin
							octets_q <= octets_q + 64'd1;
							fill_q   <= fill_q + 6'd1;
							if (fill_q == FILL_LAST) begin
								finishing_q <= 1'b0;
								state_q     <= S_CMP_GO;
							end
						end else begin
							pad_idx_q   <= fill_q;
							first_q     <= 1'b1;
							len_here_q  <= (fill_q < LEN_POS);
							finishing_q <= 1'b1;
							fill_q      <= '0;
							state_q     <= S_PAD;
						end
					end
				end
				S_PAD: begin
					first_q   <= 1'b0;
					pad_idx_q <= pad_idx_q + 6'd1;
					if (pad_idx_q == FILL_LAST) begin
						state_q <= S_CMP_GO;
					end
				end
				S_CMP_GO: begin
					state_q <= S_CMP_WAIT;
				end
				S_CMP_WAIT: begin
					if (sts.done) begin
						if (!finishing_q) begin
							state_q <= S_IDLE;
						end else if (len_here_q) begin
							word_q   <= '0;
							octets_q <= '0;
							state_q  <= S_OUT;
						end else begin
							// long tail: the length goes into a fresh block,
							// pad_idx_q has wrapped to zero
							len_here_q <= 1'b1;
							state_q    <= S_PAD;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						word_q <= word_q + 3'd1;
						if (word_q == WORD_LAST) begin
							finishing_q <= 1'b0;
							state_q     <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/sha256_chk.sv
module sha256_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       msg_valid,
	input logic       msg_ready,
	input logic       msg_operation,
	input logic       digest_valid,
	input logic       digest_ready,
	input logic [2:0] digest_word_index,
	input logic       digest_last_word
);
	import sha256_pkg::*;

	// a finish transfer closes the input right after it
	a_finish_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_ready && msg_operation == OP_FINISH |=> !msg_ready)
		else $error("input open right after a finish transfer");

	// no input while the digest sequence is still being loaded
	a_busy_during_digest: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_word_index != WORD_LAST |-> !msg_ready)
		else $error("input open while digest words remain");

	// words follow each other in order without gaps
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_ready && digest_word_index != WORD_LAST |=>
		digest_valid && digest_word_index == $past(digest_word_index) + 3'd1)
		else $error("digest word sequence broken");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> digest_last_word == (digest_word_index == WORD_LAST))
		else $error("last_word does not match word_index");

endmodule

bind sha256_stream_hasher_unit sha256_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.msg_valid         (msg.valid),
	.msg_ready         (msg.ready),
	.msg_operation     (msg.operation),
	.digest_valid      (digest.valid),
	.digest_ready      (digest.ready),
	.digest_word_index (digest.word_index),
	.digest_last_word  (digest.last_word)
);

### tb/sha256_stream_hasher_unit_tb.sv
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_tb;
	import sha256_pkg::*;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned HOLD_CYCLES  = 600;   // long digest hold-off
	localparam int unsigned CALM_AT      = 100;   // no idling from this item on
	localparam int unsigned DRAIN_CYCLES = 300;   // quiet time after the last digest word

	localparam int unsigned BLOCK_LEN   = 64;
	localparam int unsigned LEN_FIELD   = 56;     // first byte of the bit-length field
	localparam logic [7:0]  MARK_BYTE   = 8'h80;
	localparam logic [2:0]  FINAL_INDEX = 3'd7;

	// Round constants and chaining start values, kept apart from the package tables
	// so that a wrong table in the design cannot hide itself.
	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t CHAIN_START [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		word_t      word;
		logic [2:0] index;
		logic       last;
	} digest_beat_t;

	// Predicts the digest of each finished message and holds the words still owed.
	class digest_scoreboard;
		word_t          chain [8];
		logic [7:0]     blk [64];
		int unsigned    fill;
		logic [63:0]    octets;
		digest_beat_t   owed_q [$];
		int unsigned    mismatches;

		function new();
			mismatches = 0;
			foreach (blk[i]) blk[i] = 8'h00;
			restart();
		endfunction

		function void restart();
			foreach (chain[i]) chain[i] = CHAIN_START[i];
			fill   = 0;
			octets = 64'd0;
		endfunction

		function word_t rotr(word_t v, int unsigned n);
			return (v >> n) | (v << (32 - n));
		endfunction

		function void compress();
			word_t w [64];
			word_t a, b, c, d, e, f, g, h;
			word_t s0, s1, ch, mj, t1;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
			e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
			for (int i = 0; i < 64; i++) begin
				s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
				ch = (e & f) ^ (~e & g);
				t1 = h + s1 + ch + ROUND_K[i] + w[i];
				s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
				mj = (a & b) ^ (a & c) ^ (b & c);
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + s0 + mj;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
			chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
		endfunction

		function void note_transfer(logic op, logic [7:0] data);
			logic [63:0]  bits;
			digest_beat_t beat;
			if (op == OP_ABSORB) begin
				blk[fill] = data;
				octets++;
				fill++;
				if (fill == BLOCK_LEN) begin
					compress();
					fill = 0;
				end
				return;
			end
			bits = octets << 3;
			blk[fill] = MARK_BYTE;
			fill++;
			// long tail: no room for the length, flush this block first
			if (fill > LEN_FIELD) begin
				for (int i = fill; i < BLOCK_LEN; i++) blk[i] = 8'h00;
				compress();
				fill = 0;
			end
			for (int i = fill; i < LEN_FIELD; i++) blk[i] = 8'h00;
			for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
			compress();
			for (int i = 0; i < 8; i++) begin
				beat.word  = chain[i];
				beat.index = i[2:0];
				beat.last  = (i[2:0] == FINAL_INDEX);
				owed_q.push_back(beat);
			end
			restart();
		endfunction

		function void check_beat(word_t word, logic [2:0] index, logic last);
			digest_beat_t owed;
			if (owed_q.size() == 0) begin
				mismatches++;
				$display("%0t: digest expected none, actual word %h index %0d last %0b",
					$time, word, index, last);
				return;
			end
			owed = owed_q.pop_front();
			if (word !== owed.word) begin
				mismatches++;
				$display("%0t: digest_word expected %h actual %h", $time, owed.word, word);
			end
			if (index !== owed.index) begin
				mismatches++;
				$display("%0t: word_index expected %0d actual %0d", $time, owed.index, index);
			end
			if (last !== owed.last) begin
				mismatches++;
				$display("%0t: last_word expected %0b actual %0b", $time, owed.last, last);
			end
		endfunction

		function int unsigned owed_count();
			return owed_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sha256_in_if  msg_ch ();
	sha256_out_if dig_ch ();

	sha256_stream_hasher_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	digest_scoreboard sb;
	int unsigned      items_sent = 0;
	bit               calm       = 1'b0;  // last stretch of the run: nobody idles
	bit               hold_armed = 1'b0;  // start the long digest hold-off

	// Offer one item; sometimes drop valid for a burst first. Hold the item until
	// a transfer happens, then hand it to the predictor.
	task automatic send_item(input logic op, input logic [7:0] data);
		int unsigned gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid     <= 1'b1;
		msg_ch.operation <= op;
		msg_ch.data_byte <= data;
		do
			@(posedge clk);
		while (!(msg_ch.valid && msg_ch.ready));
		sb.note_transfer(op, data);
		items_sent++;
		if (items_sent >= CALM_AT) calm = 1'b1;
	endtask

	// Random message of len bytes, closed by a finish with a random ignored byte.
	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
		send_item(OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Digest side: check every transfer, idle in bursts, and once hold off for a
	// long stretch so the output register and then the input side back up.
	initial begin : digest_sink
		int unsigned stall_left;
		bit          held;
		stall_left = 0;
		held       = 1'b0;
		dig_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (dig_ch.valid && dig_ch.ready)
				sb.check_beat(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
			if (hold_armed && !held) begin
				held       = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				dig_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 9);
				dig_ch.ready <= 1'b0;
			end else begin
				dig_ch.ready <= 1'b1;
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		sb = new();
		arst_n = 1'b0;
		msg_ch.valid     <= 1'b0;
		msg_ch.operation <= OP_ABSORB;
		msg_ch.data_byte <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, with the digest side held off from the start: an empty
		// message, a second empty one stuck behind the undrained first digest,
		// then byte extremes and a byte equal to the pad mark.
		hold_armed = 1'b1;
		send_item(OP_FINISH, 8'hFF);
		send_item(OP_FINISH, 8'h00);
		send_item(OP_ABSORB, 8'hFF);
		send_item(OP_ABSORB, 8'h80);
		send_item(OP_ABSORB, 8'h00);
		send_item(OP_FINISH, 8'h55);

		// One long random message: the first block fills exactly on an absorb,
		// and more than 55 bytes are held at finish.
		send_message($urandom_range(120, 122));
		msg_ch.valid <= 1'b0;

		while (sb.owed_count() != 0) @(posedge clk);
		// Give a misbehaving block time to emit anything extra.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
hdl/sha256_pkg.sv
hdl/sha256_if.sv
hdl/sha256_sched.sv
hdl/sha256_compress.sv
hdl/sha256_stream_hasher_unit.sv
hdl/sha256_chk.sv
tb/sha256_stream_hasher_unit_tb.sv
